// ===== sv/nfv_pkg.sv =====
// ----------------------------------------------------------------------------
// nfv_pkg
// Shared constants, codes and helpers for the decimal-mark vote block.
// ----------------------------------------------------------------------------
package nfv_pkg;

  localparam int MAX_FIELD_LEN = 64;
  localparam int VOTE_WIDTH    = 16;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 7;   // position (saturates at 127) and per-field counts
  localparam int MPOS_W  = 6;   // stored mark positions
  localparam int KIND_W  = 3;
  localparam int FMT_W   = 2;
  localparam int OCNT_W  = 16;  // counter width as seen on the result item
  localparam int IUSER_W = 2;

  localparam int OUT_BITS = KIND_W + FMT_W + 4 * OCNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // tail length that marks a thousands group rather than a decimal part
  localparam logic [POS_W-1:0] GROUP_TAIL = POS_W'(3);

  // counter slots
  localparam int IDX_COMMA_DEC = 0;
  localparam int IDX_POINT_DEC = 1;
  localparam int IDX_COMMA_GRP = 2;
  localparam int IDX_POINT_GRP = 3;

  typedef logic [VOTE_WIDTH-1:0] vote_cnt_t;

  typedef enum logic [KIND_W-1:0] {
    VOTE_NONE           = 3'd0,
    VOTE_COMMA_DEC_PGRP = 3'd1,
    VOTE_POINT_DEC_CGRP = 3'd2,
    VOTE_COMMA_GRP      = 3'd3,
    VOTE_POINT_GRP      = 3'd4,
    VOTE_COMMA_DEC      = 3'd5,
    VOTE_POINT_DEC      = 3'd6
  } vote_kind_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_DEFAULT     = 2'd0,
    FMT_COMMA_DEC   = 2'd1,
    FMT_POINT_DEC   = 2'd2
  } fmt_t;

  // saturating increment
  function automatic vote_cnt_t sat_inc(input vote_cnt_t v);
    sat_inc = (v == '1) ? v : v + vote_cnt_t'(1);
  endfunction

endpackage

// ===== sv/number_format_vote.sv =====
// ----------------------------------------------------------------------------
// number_format_vote
// Per-character CSV field scanner that votes on the decimal mark in use.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one field character per item. in_tdata carries the
//   byte, in_tlast marks the final byte of a field, in_tuser carries
//   has_char (0 = empty field marker) and restart_votes (clear the four vote
//   counters before this item).
//   Result channel (out_*): one item per finished field (last byte or empty
//   marker), none for other characters. It carries the vote cast, the
//   format currently favored and the four saturating vote counters.
// Pipeline and throughput:
//   An item is held in the input register, then its field state and
//   counters update and its result lands in the output register. One item
//   is taken every cycle while the output register can accept its result;
//   the per-character update (7-bit counts, compares, 16-bit saturating
//   counter increments) is the only logic between input and output registers.
// Reset clears the field state, the vote counters and both valid flags.
// When the receiver stalls the output register holds its item; the input
// register still drains items that produce no result, and in_tready drops
// only once a result-bearing item waits behind a full output register.
// ----------------------------------------------------------------------------
module number_format_vote (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [nfv_pkg::CHAR_W-1:0] in_tdata,   // [7:0] character
  input  logic                       in_tlast,   // last byte of the field
  input  logic [nfv_pkg::IUSER_W-1:0] in_tuser,  // [0] has_char, [1] restart_votes
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [2:0] vote_kind, [4:3] format_choice, [20:5] comma_decimal_votes,
  // [36:21] point_decimal_votes, [52:37] comma_group_votes,
  // [68:53] point_group_votes, [71:69] zero
  output logic [nfv_pkg::OUT_W-1:0]  out_tdata
);
  import nfv_pkg::*;

  // input register
  logic              s0_valid_r;
  logic [CHAR_W-1:0] s0_char_r;
  logic              s0_has_r;
  logic              s0_last_r;
  logic              s0_restart_r;

  // field state
  logic [POS_W-1:0]  pos_r,   pos_nxt;
  logic [POS_W-1:0]  dig_r,   dig_nxt;
  logic [POS_W-1:0]  ncom_r,  ncom_nxt;
  logic [POS_W-1:0]  npt_r,   npt_nxt;
  logic [MPOS_W-1:0] lcom_r,  lcom_nxt;
  logic [MPOS_W-1:0] lpt_r,   lpt_nxt;
  logic              rej_r,   rej_nxt;
  vote_cnt_t         cnt_r [4];
  vote_cnt_t         cnt_nxt [4];

  // output register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [OUT_W-1:0]  out_data_nxt;

  logic              s0_produce;
  logic              out_free;
  logic              s0_go;

  // working values for the current character
  logic [POS_W-1:0]  u_pos, u_dig, u_ncom, u_npt;
  logic [MPOS_W-1:0] u_lcom, u_lpt;
  logic              u_rej;
  logic [POS_W-1:0]  tail_c, tail_p;
  vote_kind_t        kind;
  fmt_t              fmt;

  assign s0_produce = !s0_has_r || s0_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign s0_go      = s0_valid_r && (!s0_produce || out_free);
  assign in_tready  = !s0_valid_r || s0_go;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    u_pos  = pos_r;
    u_dig  = dig_r;
    u_ncom = ncom_r;
    u_npt  = npt_r;
    u_lcom = lcom_r;
    u_lpt  = lpt_r;
    u_rej  = rej_r;
    kind   = VOTE_NONE;
    fmt    = FMT_DEFAULT;
    for (int i = 0; i < 4; i++) begin
      cnt_nxt[i] = s0_restart_r ? '0 : cnt_r[i];
    end

    // scan the character against the current position
    if (pos_r >= POS_W'(MAX_FIELD_LEN)) begin
      u_rej = 1'b1;
    end else if (s0_char_r inside {[CH_ZERO:CH_NINE]}) begin
      u_dig = dig_r + POS_W'(1);
    end else if (s0_char_r == CH_COMMA) begin
      u_ncom = ncom_r + POS_W'(1);
      u_lcom = pos_r[MPOS_W-1:0];
    end else if (s0_char_r == CH_POINT) begin
      u_npt = npt_r + POS_W'(1);
      u_lpt = pos_r[MPOS_W-1:0];
    end else if (pos_r != '0 || (s0_char_r != CH_PLUS && s0_char_r != CH_MINUS)) begin
      u_rej = 1'b1;
    end
    if (pos_r != '1) begin
      u_pos = pos_r + POS_W'(1);
    end

    // characters after the last mark
    tail_c = u_pos - POS_W'(u_lcom) - POS_W'(1);
    tail_p = u_pos - POS_W'(u_lpt) - POS_W'(1);

    // cast the vote at the end of a non-empty field
    if (s0_has_r && s0_last_r && !u_rej && u_dig != '0 &&
        (u_ncom != '0 || u_npt != '0)) begin
      if (u_ncom != '0 && u_npt != '0) begin
        if (u_lcom > u_lpt && u_ncom == POS_W'(1)) begin
          kind = VOTE_COMMA_DEC_PGRP;
        end else if (u_lpt > u_lcom && u_npt == POS_W'(1)) begin
          kind = VOTE_POINT_DEC_CGRP;
        end
      end else if (u_ncom > POS_W'(1)) begin
        kind = VOTE_COMMA_GRP;
      end else if (u_npt > POS_W'(1)) begin
        kind = VOTE_POINT_GRP;
      end else if (u_ncom == POS_W'(1) && tail_c != GROUP_TAIL) begin
        kind = VOTE_COMMA_DEC;
      end else if (u_npt == POS_W'(1) && tail_p != GROUP_TAIL) begin
        kind = VOTE_POINT_DEC;
      end
    end

    case (kind)
      VOTE_COMMA_DEC_PGRP: begin
        cnt_nxt[IDX_COMMA_DEC] = sat_inc(cnt_nxt[IDX_COMMA_DEC]);
        cnt_nxt[IDX_POINT_GRP] = sat_inc(cnt_nxt[IDX_POINT_GRP]);
      end
      VOTE_POINT_DEC_CGRP: begin
        cnt_nxt[IDX_POINT_DEC] = sat_inc(cnt_nxt[IDX_POINT_DEC]);
        cnt_nxt[IDX_COMMA_GRP] = sat_inc(cnt_nxt[IDX_COMMA_GRP]);
      end
      VOTE_COMMA_GRP: cnt_nxt[IDX_COMMA_GRP] = sat_inc(cnt_nxt[IDX_COMMA_GRP]);
      VOTE_POINT_GRP: cnt_nxt[IDX_POINT_GRP] = sat_inc(cnt_nxt[IDX_POINT_GRP]);
      VOTE_COMMA_DEC: cnt_nxt[IDX_COMMA_DEC] = sat_inc(cnt_nxt[IDX_COMMA_DEC]);
      VOTE_POINT_DEC: cnt_nxt[IDX_POINT_DEC] = sat_inc(cnt_nxt[IDX_POINT_DEC]);
      default: ;
    endcase

    // pick the favored format from the counters after the vote
    if (cnt_nxt[IDX_POINT_DEC] == '0 &&
        (cnt_nxt[IDX_COMMA_DEC] != '0 || cnt_nxt[IDX_POINT_GRP] != '0)) begin
      fmt = FMT_COMMA_DEC;
    end else if (cnt_nxt[IDX_COMMA_DEC] == '0 && cnt_nxt[IDX_COMMA_GRP] != '0) begin
      fmt = FMT_POINT_DEC;
    end

    // drop the field state at a field end, else keep the scan
    if (s0_produce) begin
      pos_nxt  = '0;
      dig_nxt  = '0;
      ncom_nxt = '0;
      npt_nxt  = '0;
      lcom_nxt = '0;
      lpt_nxt  = '0;
      rej_nxt  = 1'b0;
    end else begin
      pos_nxt  = u_pos;
      dig_nxt  = u_dig;
      ncom_nxt = u_ncom;
      npt_nxt  = u_npt;
      lcom_nxt = u_lcom;
      lpt_nxt  = u_lpt;
      rej_nxt  = u_rej;
    end

    out_data_nxt = OUT_W'({OCNT_W'(cnt_nxt[IDX_POINT_GRP]),
                           OCNT_W'(cnt_nxt[IDX_COMMA_GRP]),
                           OCNT_W'(cnt_nxt[IDX_POINT_DEC]),
                           OCNT_W'(cnt_nxt[IDX_COMMA_DEC]),
                           fmt, kind});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      dig_r       <= '0;
      ncom_r      <= '0;
      npt_r       <= '0;
      lcom_r      <= '0;
      lpt_r       <= '0;
      rej_r       <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      // take a new item whenever the input register empties
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      // advance the field state and counters
      if (s0_go) begin
        pos_r  <= pos_nxt;
        dig_r  <= dig_nxt;
        ncom_r <= ncom_nxt;
        npt_r  <= npt_nxt;
        lcom_r <= lcom_nxt;
        lpt_r  <= lpt_nxt;
        rej_r  <= rej_nxt;
        for (int i = 0; i < 4; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
      // load or drain the output register
      if (s0_go && s0_produce) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_char_r    <= in_tdata;
      s0_has_r     <= in_tuser[0];
      s0_last_r    <= in_tlast;
      s0_restart_r <= in_tuser[1];
    end
    if (s0_go && s0_produce) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a finished field leaves a clean scan state behind
  a_field_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_go && s0_produce) |=> (pos_r == '0 && rej_r == 1'b0 && dig_r == '0))
    else $error("field state not cleared after field end");

  // counts never run past the field length limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_r <= POS_W'(MAX_FIELD_LEN)) && (ncom_r <= POS_W'(MAX_FIELD_LEN)) &&
    (npt_r <= POS_W'(MAX_FIELD_LEN)))
    else $error("per-field count exceeds field length limit");

  // a comma-decimal vote shows up in its counter
  a_comma_vote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[KIND_W-1:0] == VOTE_COMMA_DEC ||
                     out_data_r[KIND_W-1:0] == VOTE_COMMA_DEC_PGRP))
    |-> (out_data_r[KIND_W+FMT_W +: OCNT_W] != '0 || VOTE_WIDTH < OCNT_W))
    else $error("comma-decimal vote without counter");

  // no result is invented for a mid-field character
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(s0_go && s0_produce)) |=> !out_valid_r)
    else $error("result appeared without a finished field");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal-mark vote block. It streams field
// characters into the block, predicts each vote and counter set in a local
// model of the scanner, and compares every result item field by field. It
// covers short directed fields, restarts and empty markers, long fields,
// a burst of votes at full rate and random traffic under varying
// back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import nfv_pkg::*;

  // Consecutive cycles without any handshake before the run is declared hung.
  // The worst legal gap (82% sender idle or receiver stall) stays far below.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to watch after the last result for stray items.
  localparam int DRAIN_CYCLES = 16;
  // Pairs of two-mark fields sent back to back in the vote burst.
  localparam int BURST_FIELDS = 40;

  localparam string MARK_SOUP = "0123456789,.+-";

  typedef struct packed {
    vote_kind_t          kind;
    fmt_t                fmt;
    logic [OCNT_W-1:0]   cd;
    logic [OCNT_W-1:0]   pd;
    logic [OCNT_W-1:0]   cg;
    logic [OCNT_W-1:0]   pg;
  } vote_rpt_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [CHAR_W-1:0]  in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic [IUSER_W-1:0] in_tuser   = '0;   // [0] has_char, [1] restart_votes
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  // predictor state: the field being scanned and the four vote tallies
  logic [POS_W-1:0]   fld_pos      = '0;
  logic [POS_W-1:0]   fld_digits   = '0;
  logic [POS_W-1:0]   fld_commas   = '0;
  logic [POS_W-1:0]   fld_points   = '0;
  logic [MPOS_W-1:0]  fld_comma_at = '0;
  logic [MPOS_W-1:0]  fld_point_at = '0;
  logic               fld_bad      = 1'b0;
  vote_cnt_t          tally [4]    = '{default: '0};

  vote_rpt_t          votes_pending [$];
  vote_rpt_t          head;

  int gap_pct    = 0;     // chance in 100 that the sender idles before an item
  int stall_pct  = 0;     // chance in 100 that the receiver stalls a cycle
  int restart_pm = 0;     // chance in 1000 that an item carries restart_votes
  int items_sent = 0;
  int fails      = 0;
  int quiet_cycles = 0;

  number_format_vote dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic void clear_field();
    fld_pos      = '0;
    fld_digits   = '0;
    fld_commas   = '0;
    fld_points   = '0;
    fld_comma_at = '0;
    fld_point_at = '0;
    fld_bad      = 1'b0;
  endfunction

  function automatic void bump(input int slot);
    if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
  endfunction

  // A single mark followed by exactly three characters reads as grouping.
  function automatic bit is_decimal_tail(input logic [MPOS_W-1:0] at);
    return (int'(fld_pos) - int'(at) - 1) != int'(GROUP_TAIL);
  endfunction

  // Judge the finished field and add its vote to the tallies.
  function automatic vote_kind_t judge_field();
    if (fld_bad || fld_pos == 0 || fld_digits == 0 || (fld_commas == 0 && fld_points == 0))
      return VOTE_NONE;
    if (fld_commas != 0 && fld_points != 0) begin
      if (fld_comma_at > fld_point_at && fld_commas == 1) begin
        bump(IDX_COMMA_DEC);
        bump(IDX_POINT_GRP);
        return VOTE_COMMA_DEC_PGRP;
      end
      if (fld_point_at > fld_comma_at && fld_points == 1) begin
        bump(IDX_POINT_DEC);
        bump(IDX_COMMA_GRP);
        return VOTE_POINT_DEC_CGRP;
      end
      return VOTE_NONE;
    end
    if (fld_commas > 1) begin
      bump(IDX_COMMA_GRP);
      return VOTE_COMMA_GRP;
    end
    if (fld_points > 1) begin
      bump(IDX_POINT_GRP);
      return VOTE_POINT_GRP;
    end
    if (fld_commas == 1 && is_decimal_tail(fld_comma_at)) begin
      bump(IDX_COMMA_DEC);
      return VOTE_COMMA_DEC;
    end
    if (fld_points == 1 && is_decimal_tail(fld_point_at)) begin
      bump(IDX_POINT_DEC);
      return VOTE_POINT_DEC;
    end
    return VOTE_NONE;
  endfunction

  function automatic fmt_t favored_format();
    if (tally[IDX_POINT_DEC] == 0 && (tally[IDX_COMMA_DEC] != 0 || tally[IDX_POINT_GRP] != 0))
      return FMT_COMMA_DEC;
    if (tally[IDX_COMMA_DEC] == 0 && tally[IDX_COMMA_GRP] != 0)
      return FMT_POINT_DEC;
    return FMT_DEFAULT;
  endfunction

  // Advance the scanner by one accepted item; queue a result when it ends a field.
  task automatic tally_char(input logic [CHAR_W-1:0] ch, input logic has, input logic lst,
                            input logic rst);
    vote_rpt_t r;
    if (rst) tally = '{default: '0};
    if (!has) begin
      clear_field();
      r.kind = VOTE_NONE;
    end else begin
      if (fld_pos >= MAX_FIELD_LEN) begin
        fld_bad = 1'b1;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        fld_digits = fld_digits + 1'b1;
      end else if (ch == CH_COMMA) begin
        fld_commas   = fld_commas + 1'b1;
        fld_comma_at = fld_pos[MPOS_W-1:0];
      end else if (ch == CH_POINT) begin
        fld_points   = fld_points + 1'b1;
        fld_point_at = fld_pos[MPOS_W-1:0];
      end else if (fld_pos != 0 || (ch != CH_PLUS && ch != CH_MINUS)) begin
        fld_bad = 1'b1;
      end
      if (fld_pos != '1) fld_pos = fld_pos + 1'b1;
      if (!lst) return;
      r.kind = judge_field();
      clear_field();
    end
    r.fmt = favored_format();
    r.cd  = OCNT_W'(tally[IDX_COMMA_DEC]);
    r.pd  = OCNT_W'(tally[IDX_POINT_DEC]);
    r.cg  = OCNT_W'(tally[IDX_COMMA_GRP]);
    r.pg  = OCNT_W'(tally[IDX_POINT_GRP]);
    votes_pending = {votes_pending, r};
  endtask

  // ------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (votes_pending.size() == 0) begin
        $error("result item arrived with no vote pending");
        fails++;
      end else begin
        head = votes_pending.pop_front();
        check_field("vote_kind",           int'(head.kind), int'(out_tdata[2:0]));
        check_field("format_choice",       int'(head.fmt),  int'(out_tdata[4:3]));
        check_field("comma_decimal_votes", int'(head.cd),   int'(out_tdata[20:5]));
        check_field("point_decimal_votes", int'(head.pd),   int'(out_tdata[36:21]));
        check_field("comma_group_votes",   int'(head.cg),   int'(out_tdata[52:37]));
        check_field("point_group_votes",   int'(head.pg),   int'(out_tdata[68:53]));
      end
    end
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------
  function automatic logic roll_restart();
    return $urandom_range(999) < restart_pm;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CH_ZERO + CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [CHAR_W-1:0] CH_ONE_OR_ZERO();
    return CH_ZERO + CHAR_W'($urandom_range(1));
  endfunction

  // Present one item, hold it until accepted, then predict it. Valid stays
  // high into the next call unless that call starts with an idle gap.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic has, input logic lst,
                           input logic rst);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tdata  <= ch;
    in_tlast  <= lst;
    in_tuser  <= {rst, has};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tally_char(ch, has, lst, rst);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, i == s.len() - 1, 1'b0);
  endtask

  task automatic send_bytes(input logic [CHAR_W-1:0] txt [$]);
    int i;
    for (i = 0; i < txt.size(); i++)
      send_item(txt[i], 1'b1, i == txt.size() - 1, roll_restart());
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (votes_pending.size() != 0) @(posedge clk);
  endtask

  // Well-formed number: optional sign, digits with optional grouping marks,
  // optional decimal part with the other mark (sometimes the same one).
  task automatic build_number(output logic [CHAR_W-1:0] txt [$]);
    logic              use_grp;
    logic [CHAR_W-1:0] gmark;
    logic [CHAR_W-1:0] dmark;
    int                n_int;
    int                i;
    txt = {};
    if ($urandom_range(4) == 0) txt = {txt, ($urandom_range(1) ? CH_PLUS : CH_MINUS)};
    use_grp = 1'($urandom_range(1));
    gmark   = $urandom_range(1) ? CH_COMMA : CH_POINT;
    n_int   = $urandom_range(1, 7);
    for (i = 0; i < n_int; i++) begin
      if (use_grp && i > 0 && (n_int - i) % 3 == 0) txt = {txt, gmark};
      txt = {txt, rand_digit()};
    end
    if ($urandom_range(9) < 6) begin
      if ($urandom_range(9) < 8)
        dmark = (gmark == CH_COMMA) ? CH_POINT : CH_COMMA;
      else
        dmark = gmark;
      txt = {txt, dmark};
      repeat ($urandom_range(1, 4)) txt = {txt, rand_digit()};
    end
  endtask

  task automatic send_random_field();
    logic [CHAR_W-1:0] txt [$];
    int                pick;
    int                i;
    int                n;
    pick = $urandom_range(99);
    txt  = {};
    if (pick < 55) begin
      build_number(txt);
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 10)) txt = {txt, CHAR_W'(MARK_SOUP[$urandom_range(13)])};
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 6)) txt = {txt, CHAR_W'($urandom_range(255))};
    end else if (pick < 95) begin
      // empty marker, sometimes cutting off a field in progress
      if (pick >= 90) begin
        build_number(txt);
        for (i = 0; i < txt.size(); i++)
          send_item(txt[i], 1'b1, 1'b0, roll_restart());
      end
      send_item(CHAR_W'($urandom()), 1'b0, 1'($urandom()), roll_restart());
      return;
    end else begin
      // long field straddling the length limit
      n = $urandom_range(60, 70);
      repeat (n) txt = {txt, rand_digit()};
      txt[$urandom_range(n - 1)] = $urandom_range(1) ? CH_COMMA : CH_POINT;
    end
    send_bytes(txt);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // One field per vote kind, signs, rejected characters and byte extremes.
  task automatic test_directed_fields();
    send_text("1,5");        // comma decimal
    send_text("1.234");      // three-digit tail: no vote
    send_text("1,234.5");    // point decimal, comma grouping
    send_text("1.234,5");    // comma decimal, point grouping
    send_text("1,234,567");  // comma grouping
    send_text("1.234.567");  // point grouping
    send_text("-2.5");       // leading sign
    send_text("+7,25");
    send_text("12");         // no mark
    send_text("1-2");        // sign not in front
    send_text(",.");         // no digit
    send_text("1,2.3,4");    // both marks, neither pattern fits
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
  endtask

  // Restart on non-last and empty items, empty markers ending partial fields.
  task automatic test_restart_and_empty();
    send_text("3,5");
    send_item(CH_ZERO, 1'b1, 1'b0, 1'b1);
    send_item(CH_POINT, 1'b1, 1'b0, 1'b0);
    send_item(CH_NINE, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(CH_ONE_OR_ZERO(), 1'b1, 1'b0, 1'b0);
    send_item(CH_COMMA, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_text("4.5");
  endtask

  // Fields at, just over and far over the length limit.
  task automatic test_long_fields();
    logic [CHAR_W-1:0] txt [$];
    txt = {};
    repeat (MAX_FIELD_LEN - 1) txt = {txt, rand_digit()};
    txt = {txt, CH_COMMA};
    send_bytes(txt);
    txt.push_front(CH_NINE);
    send_bytes(txt);
    txt = {};
    repeat (130) txt = {txt, rand_digit()};
    txt = {txt, CH_POINT};
    send_bytes(txt);
  endtask

  // Pile votes onto all four counters at full rate.
  task automatic test_vote_burst();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(CH_ZERO, 1'b0, 1'b1, 1'b1);
    repeat (BURST_FIELDS) begin
      send_text(".,1");
      send_text(",.1");
    end
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int n_items,
                                     input bit hold_midway);
    int stop_at;
    int mid;
    gap_pct    = gap;
    stall_pct  = stall;
    restart_pm = 20;
    stop_at    = items_sent + n_items;
    mid        = items_sent + n_items / 2;
    while (items_sent < stop_at) begin
      if (hold_midway && items_sent >= mid) begin
        wait_drained();
        hold_midway = 1'b0;
      end
      send_random_field();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_fields();
    test_restart_and_empty();
    test_long_fields();
    test_vote_burst();
    test_random_traffic(0,  0,  300, 1'b0);
    test_random_traffic(82, 0,  300, 1'b1);
    test_random_traffic(0,  82, 300, 1'b0);
    test_random_traffic(31, 31, 300, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
